FILE: rtl/ttl_cache_min_ttl_replace_defines.svh
// Assertion macros for the lifetime-aged answer cache.
`ifndef TTL_CACHE_MIN_TTL_REPLACE_DEFINES_SVH
`define TTL_CACHE_MIN_TTL_REPLACE_DEFINES_SVH

`ifndef SYNTHESIS
`define TTLC_ASSERT_IMPLY(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);
`define TTLC_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);
`else
`define TTLC_ASSERT_IMPLY(label, clk, rst, cond, prop, msg)
`define TTLC_ASSERT_NEXT(label, clk, rst, cond, prop, msg)
`endif

`endif

FILE: rtl/ttlc_pkg.sv
// Types, constants and helpers shared by the answer cache modules.
`default_nettype none

package ttlc_pkg;

   localparam int TABLE_ENTRIES = 16;
   localparam int KEY_BITS      = 48;
   localparam int IDX_BITS      = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_LOOKUP = 1'b1;

   typedef logic [KEY_BITS-1:0] key_type;
   typedef logic [IDX_BITS-1:0] idx_type;

   typedef struct packed {
      logic        kind;
      logic [31:0] elapsed_seconds;
      logic [47:0] name_key;
      logic [30:0] entry_ttl;
      logic [15:0] entry_handle;
   } req_type;

   typedef struct packed {
      logic        hit;
      logic [15:0] found_handle;
      logic [30:0] found_ttl;
      logic        evicted;
      logic [47:0] evicted_key;
      logic [15:0] evicted_handle;
      logic [3:0]  slot_used;
   } rsp_type;

   // Search record that walks the cell chain, one cell per cycle.
   typedef struct packed {
      logic        kind;
      logic [31:0] delta;
      key_type     key;
      logic        empty_found;
      idx_type     empty_idx;
      logic        min_ok;
      idx_type     min_idx;
      logic [30:0] min_life;
      key_type     min_key;
      logic [15:0] min_handle;
      logic        hit;
      idx_type     hit_idx;
      logic [30:0] hit_life;
      logic [15:0] hit_handle;
   } scan_type;

   // Slot write broadcast to every cell.
   typedef struct packed {
      logic        en;
      idx_type     idx;
      key_type     key;
      logic [30:0] life;
      logic [15:0] handle;
   } wr_type;

   function automatic key_type key_from_port(input logic [47:0] k);
      logic [63:0] w;
      w = 64'(k);
      return w[KEY_BITS-1:0];
   endfunction

   function automatic logic [47:0] key_to_port(input key_type k);
      logic [63:0] w;
      w = 64'(k);
      return w[47:0];
   endfunction

   function automatic logic [3:0] slot_field(input idx_type i);
      logic [31:0] w;
      w = 32'(i);
      return w[3:0];
   endfunction

endpackage

`default_nettype wire

FILE: rtl/ttlc_cell.sv
// One table slot: holds its entry, ages it and updates the passing search record.
`default_nettype none

module ttlc_cell
   import ttlc_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire idx_type  idx,
   input  wire logic     tok_valid_in,
   input  wire scan_type tok_in,
   input  wire wr_type   wr,
   output logic          tok_valid_ff,
   output scan_type      tok_ff
);

   logic        valid_ff;
   key_type     key_ff;
   logic [30:0] life_ff;
   logic [15:0] handle_ff;

   logic [30:0] aged;
   scan_type    tok_in_next;

   always_comb begin
      if ({1'b0, life_ff} <= tok_in.delta) begin
         aged = 31'd0;
      end else begin
         aged = life_ff - tok_in.delta[30:0];
      end

      tok_in_next = tok_in;
      if (valid_ff) begin
         if (tok_in.kind == KIND_INSERT) begin
            // strict compare keeps the lowest index among equal lifetimes
            if (!tok_in.min_ok || (aged < tok_in.min_life)) begin
               tok_in_next.min_ok     = 1'b1;
               tok_in_next.min_idx    = idx;
               tok_in_next.min_life   = aged;
               tok_in_next.min_key    = key_ff;
               tok_in_next.min_handle = handle_ff;
            end
         end else if (!tok_in.hit && (key_ff == tok_in.key)) begin
            tok_in_next.hit        = 1'b1;
            tok_in_next.hit_idx    = idx;
            tok_in_next.hit_life   = aged;
            tok_in_next.hit_handle = handle_ff;
         end
      end else if (!tok_in.empty_found) begin
         tok_in_next.empty_found = 1'b1;
         tok_in_next.empty_idx   = idx;
      end
   end

   always_ff @(posedge clock) begin
      tok_ff <= tok_in_next;
      if (reset) begin
         tok_valid_ff <= 1'b0;
         valid_ff     <= 1'b0;
      end else begin
         tok_valid_ff <= tok_valid_in;
         if (wr.en && (wr.idx == idx)) begin
            valid_ff <= 1'b1;
         end
      end
      if (tok_valid_in && valid_ff) begin
         life_ff <= aged;
      end
      if (wr.en && (wr.idx == idx)) begin
         key_ff    <= wr.key;
         life_ff   <= wr.life;
         handle_ff <= wr.handle;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/ttl_cache_min_ttl_replace.sv
// Top level of the lifetime-aged answer cache with smallest-lifetime replacement.
`default_nettype none
`include "ttl_cache_min_ttl_replace_defines.svh"

// The cache holds TABLE_ENTRIES slots, one per cell in a chain. Each request
// item launches a search record into cell 0; the record moves one cell per
// cycle, and as it passes, each cell ages its lifetime by the item's elapsed
// seconds (flooring at zero) and folds itself into the record: first empty
// slot, first smallest lifetime, first tag match. When the record leaves the
// last cell, an insert writes its target slot (lowest empty, otherwise the
// lowest-index smallest lifetime, reported as evicted) and the result item is
// registered. One item is in flight at a time: the result is registered once
// the record has passed the launch register and the walk through the cell
// chain, and the next item is accepted only once the result has been taken.
// Slots never written are never read, since every cell gates its contents
// with its own valid bit, cleared by reset.
module ttl_cache_min_ttl_replace
   import ttlc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   logic     busy_ff;
   logic     launch_valid_ff;
   scan_type launch_ff;
   logic     rsp_valid_ff;
   rsp_type  rsp_ff;

   logic     tok_valid [TABLE_ENTRIES+1];
   scan_type tok       [TABLE_ENTRIES+1];
   logic [TABLE_ENTRIES:0] tok_valid_vec;

   scan_type launch_in;
   scan_type last;
   logic     last_valid;
   idx_type  target;
   wr_type   wr;
   rsp_type  rsp_in;
   logic     req_accept;

   assign req_ready  = !busy_ff && !rsp_valid_ff;
   assign req_accept = req_valid && req_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   // Fresh search record built from the request item.
   always_comb begin
      launch_in             = '0;
      launch_in.kind        = req_data.kind;
      launch_in.delta       = req_data.elapsed_seconds;
      launch_in.key         = key_from_port(req_data.name_key);
      // hold the insert payload in the launch register's spare fields
      launch_in.min_life    = req_data.entry_ttl;
      launch_in.min_handle  = req_data.entry_handle;
   end

   assign tok_valid[0] = launch_valid_ff;
   assign tok[0]       = launch_ff;

   for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
      ttlc_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .idx          (IDX_BITS'(i)),
         .tok_valid_in (tok_valid[i]),
         .tok_in       (tok[i]),
         .wr           (wr),
         .tok_valid_ff (tok_valid[i+1]),
         .tok_ff       (tok[i+1])
      );
   end

   for (genvar i = 0; i <= TABLE_ENTRIES; i++) begin : g_vec
      assign tok_valid_vec[i] = tok_valid[i];
   end

   assign last       = tok[TABLE_ENTRIES];
   assign last_valid = tok_valid[TABLE_ENTRIES];

   // Pick the slot to write and build the result item.
   always_comb begin
      target    = last.empty_found ? last.empty_idx : last.min_idx;

      wr        = '0;
      wr.en     = last_valid && (last.kind == KIND_INSERT);
      wr.idx    = target;
      wr.key    = last.key;
      wr.life   = launch_ff.min_life;
      wr.handle = launch_ff.min_handle;

      rsp_in    = '0;
      if (last.kind == KIND_INSERT) begin
         rsp_in.slot_used = slot_field(target);
         if (!last.empty_found) begin
            rsp_in.evicted        = 1'b1;
            rsp_in.evicted_key    = key_to_port(last.min_key);
            rsp_in.evicted_handle = last.min_handle;
         end
      end else if (last.hit) begin
         rsp_in.hit          = 1'b1;
         rsp_in.found_handle = last.hit_handle;
         rsp_in.found_ttl    = last.hit_life;
         rsp_in.slot_used    = slot_field(last.hit_idx);
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         launch_ff <= launch_in;
      end
      if (last_valid) begin
         rsp_ff <= rsp_in;
      end
      if (reset) begin
         busy_ff         <= 1'b0;
         launch_valid_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         launch_valid_ff <= req_accept;
         if (req_accept) begin
            busy_ff <= 1'b1;
         end else if (last_valid) begin
            busy_ff <= 1'b0;
         end
         if (last_valid) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Hold the launch register's insert payload: cell 0 sees the launch record
   // with min_ok clear, so the spare min fields never steer a replacement.

   `TTLC_ASSERT_NEXT(a_accept_busy, clock, reset, req_accept, busy_ff && !req_ready, "accepted item did not mark the block busy")
   `TTLC_ASSERT_IMPLY(a_one_record, clock, reset, 1'b1, $onehot0(tok_valid_vec), "more than one search record in the chain")
   `TTLC_ASSERT_NEXT(a_last_rsp, clock, reset, last_valid, rsp_valid_ff && !busy_ff, "search record left the chain without a result")
   `TTLC_ASSERT_IMPLY(a_last_busy, clock, reset, last_valid, busy_ff && !rsp_valid_ff, "search record seen while idle or result pending")

endmodule

`default_nettype wire
